// File: rtl/lap5_pkg.sv
// Shared types and constants for the 5x5 Laplacian edge filter.
package lap5_pkg;

    localparam int WIN_N    = 5;     // window is WIN_N x WIN_N
    localparam int PIX_W    = 8;
    localparam int ROW_W    = 13;    // padded row count reaches MAX_HEIGHT + 1
    localparam int MAX_HEIGHT = 4096;
    localparam int WCFG_W   = 11;
    localparam int HCFG_W   = 13;
    localparam int SUM_W    = 12;    // each signed half of the response fits 0..4080
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RST = 13'd1024;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] col_t;       // one window column, top row at index 0
    typedef pix_t [3:0]       line_word_t; // four stored rows of one column

    typedef struct packed {
        logic clear;      // restart: wipe the whole window
        logic load;       // take a new column
        logic start_row;  // new column is the first of a row: older columns go to zero
    } win_ctl_t;

endpackage

// File: rtl/laplacian_5x5_edge_filter_core.sv
// Top level of the 5x5 Laplacian edge filter: stream control, config port, output stage.
//
// The block takes one 8-bit gray pixel per beat in raster order, image_width+2 beats per
// row for image_height+2 rows; beats beyond the right or bottom image edge are padding and
// their pixel is ignored. From padded row 2 and column 2 on, each beat yields one result
// beat carrying |Laplacian| clamped to 255 for the pixel two rows up and two columns left;
// tlast marks the result for the last image pixel. While m_tready does not stall the output,
// it sustains one beat per clock: the line store is one word of four rows per column, read
// and written once per beat at the same address, so the window gets all five rows of a
// column in a single access. A result passes the memory read, window, kernel sums and
// output register after its beat is accepted, and every stage holds independently, so beats
// keep being accepted while results wait as long as the pipe has a free slot. The line store
// is not cleared after reset; only rows already written in the current frame are ever used.
// Writing either register restarts the frame; do so only with the block idle.
module laplacian_5x5_edge_filter_core
    import lap5_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_pixel
    output logic              m_tlast,   // frame_end
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 2);   // padded column reaches MAX_WIDTH + 1

    // configuration
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic              cfg_wr;
    logic [CW-1:0]     w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [CW-1:0]     w_last;
    logic [ROW_W-1:0]  h_last;

    // raster position
    logic [CW-1:0]     col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;

    // stage 0 decode
    logic              accept;
    logic              in_col;
    logic              s0_last;
    logic              s0_emit;
    logic [WIN_N-1:0]  s0_row_ok;
    logic              store_wr;

    // pipeline stages
    logic              p1_valid_reg;
    pix_t              p1_pix_reg;
    logic [WIN_N-1:0]  p1_row_ok_reg;
    logic [1:0]        p1_slot_reg;
    logic              p1_start_reg;
    logic              p1_emit_reg;
    logic              p1_last_reg;
    logic              p2_valid_reg;
    logic              p2_emit_reg;
    logic              p2_last_reg;
    logic              p3_valid_reg;
    logic              p3_last_reg;
    logic              m_tvalid_reg;
    pix_t              m_tdata_reg;
    logic              m_tlast_reg;

    logic              en1, en2, en3, out_en;
    line_word_t        rd_word;
    col_t              p1_col;
    win_ctl_t          win_ctl;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  neg_sum;
    logic [SUM_W:0]    diff;
    logic [SUM_W-1:0]  mag;
    pix_t              result_pix;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_reg  <= pwdata[WCFG_W-1:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IDX_HEIGHT: prdata = APB_DW'(height_reg);
            default:        prdata = '0;
        endcase
    end

    // clamp the registers into the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        w_last = w_eff + CW'(1);
        h_last = h_eff + ROW_W'(1);
    end

    // ---------------------------------------------------------------- handshake
    // each stage advances when the one after it is empty or advancing
    assign out_en   = !m_tvalid_reg || m_tready;
    assign en3      = !p3_valid_reg || out_en;
    assign en2      = !p2_valid_reg || en3;
    assign en1      = !p1_valid_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    // ---------------------------------------------------------------- stage 0: decode
    always_comb begin
        in_col   = col_pos_reg < w_eff;
        s0_emit  = (row_pos_reg >= ROW_W'(2)) && (col_pos_reg >= CW'(2));
        s0_last  = (row_pos_reg == h_last) && (col_pos_reg == w_last);
        // rows r-4 .. r-1 come from the store; drop those above or below the image
        for (int k = 0; k < WIN_N - 1; k++) begin
            s0_row_ok[k] = in_col
                && ((ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(k) >= (ROW_W+1)'(WIN_N - 1))
                && ((ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(k)
                    < (ROW_W+1)'(h_eff) + (ROW_W+1)'(WIN_N - 1));
        end
        s0_row_ok[WIN_N-1] = in_col && (row_pos_reg < h_eff);
        store_wr = accept && s0_row_ok[WIN_N-1];
    end

    // advance the raster position, wrapping at the end of a padded row and frame
    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept) begin
            if (col_pos_reg == w_last) begin
                col_pos_next = '0;
                row_pos_next = (row_pos_reg == h_last) ? '0 : row_pos_reg + ROW_W'(1);
            end else begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    lap5_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .wr_en   (store_wr),
        .addr    (col_pos_reg[ADDR_W-1:0]),
        .wr_slot (row_pos_reg[1:0]),
        .wr_data (s_tdata),
        .rd_data (rd_word)
    );

    // ---------------------------------------------------------------- stage 1: column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en1) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg    <= s_tdata;
            p1_row_ok_reg <= s0_row_ok;
            p1_slot_reg   <= row_pos_reg[1:0];
            p1_start_reg  <= (col_pos_reg == '0);
            p1_emit_reg   <= s0_emit;
            p1_last_reg   <= s0_last;
        end
    end

    // row r-4+k sits in slot (r+k) mod 4
    always_comb begin
        logic [1:0] slot;
        for (int k = 0; k < WIN_N - 1; k++) begin
            slot      = p1_slot_reg + 2'(k);
            p1_col[k] = p1_row_ok_reg[k] ? rd_word[slot] : '0;
        end
        p1_col[WIN_N-1] = p1_row_ok_reg[WIN_N-1] ? p1_pix_reg : '0;
    end

    assign win_ctl.clear     = cfg_wr;
    assign win_ctl.load      = p1_valid_reg && en2;
    assign win_ctl.start_row = p1_start_reg;

    lap5_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .col_in  (p1_col),
        .sum_en  (en3),
        .pos_sum (pos_sum),
        .neg_sum (neg_sum)
    );

    // ---------------------------------------------------------------- stage 2/3: window, sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (en2) begin
                p2_valid_reg <= p1_valid_reg;
            end
            // drop beats that fall in the first two padded rows or columns
            if (en3) begin
                p3_valid_reg <= p2_valid_reg && p2_emit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            p2_emit_reg <= p1_emit_reg;
            p2_last_reg <= p1_last_reg;
        end
        if (en3) begin
            p3_last_reg <= p2_last_reg;
        end
    end

    // ---------------------------------------------------------------- output: abs and clamp
    always_comb begin
        diff       = {1'b0, pos_sum} - {1'b0, neg_sum};
        mag        = diff[SUM_W] ? (neg_sum - pos_sum) : diff[SUM_W-1:0];
        result_pix = (mag > SUM_W'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_tdata_reg <= result_pix;
            m_tlast_reg <= p3_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // the last padded beat of a frame sends the position back to the origin
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s0_last && !cfg_wr |=> col_pos_reg == '0 && row_pos_reg == '0)
        else $error("raster position did not wrap after the last beat of a frame");

    // the column never runs past the right padding column
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_pos_reg <= w_last)
        else $error("column position beyond the padded row");

    // the window must not move while the beat that owns it is still held
    a_window_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg && !en3 |-> !win_ctl.load)
        else $error("window overwritten under a stalled beat");

    // a frame end in the sum stage reaches the output register when the output advances
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_valid_reg && p3_last_reg && out_en |=> m_tvalid && m_tlast)
        else $error("frame end lost on its way to the output");
`endif

endmodule

// File: rtl/lap5_line_store.sv
// Line store: one word per column holding the last four image rows.
module lap5_line_store
    import lap5_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [1:0]        wr_slot,
    input  pix_t              wr_data,
    output line_word_t        rd_data
);

    line_word_t store_reg [DEPTH];
    line_word_t rd_data_reg;

    // read-before-write on the shared address: the slot being written returns its old row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[addr][wr_slot] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lap5_window.sv
// 5x5 window registers and the registered positive and negative kernel sums.
module lap5_window
    import lap5_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  win_ctl_t         ctl,
    input  col_t             col_in,
    input  logic             sum_en,
    output logic [SUM_W-1:0] pos_sum,
    output logic [SUM_W-1:0] neg_sum
);

    pix_t win_reg [WIN_N][WIN_N];   // [column, oldest first][row, top first]
    logic [SUM_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] neg_reg, neg_next;
    logic [SUM_W-1:0] ones_sum;
    logic [SUM_W-1:0] twos_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int j = 0; j < WIN_N; j++) begin
                for (int k = 0; k < WIN_N; k++) begin
                    win_reg[j][k] <= '0;
                end
            end
        end else if (ctl.load) begin
            for (int j = 0; j < WIN_N - 1; j++) begin
                for (int k = 0; k < WIN_N; k++) begin
                    win_reg[j][k] <= ctl.start_row ? '0 : win_reg[j+1][k];
                end
            end
            for (int k = 0; k < WIN_N; k++) begin
                win_reg[WIN_N-1][k] <= col_in[k];
            end
        end
    end

    // taps of weight -1 and -2 around a centre of weight 16
    always_comb begin
        ones_sum = SUM_W'(win_reg[2][0]) + SUM_W'(win_reg[1][1]) + SUM_W'(win_reg[3][1])
                 + SUM_W'(win_reg[0][2]) + SUM_W'(win_reg[4][2]) + SUM_W'(win_reg[1][3])
                 + SUM_W'(win_reg[3][3]) + SUM_W'(win_reg[2][4]);
        twos_sum = SUM_W'(win_reg[2][1]) + SUM_W'(win_reg[1][2]) + SUM_W'(win_reg[3][2])
                 + SUM_W'(win_reg[2][3]);
        neg_next = ones_sum + {twos_sum[SUM_W-2:0], 1'b0};
        pos_next = {win_reg[2][2], 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
    end

    assign pos_sum = pos_reg;
    assign neg_sum = neg_reg;

endmodule
